### rtl/avd_pkg.sv
// Package for the averaging voltmeter display: shared widths, types and codes.
// It also holds the seven-segment lookup function.
// It depends on nothing else and every module of the block uses it.
package avd_pkg;

    localparam int SAMPLE_W        = 10;
    localparam int DIGIT_W         = 4;
    localparam int SEG_W           = 7;
    localparam int CNT_W           = 8;
    localparam int HISTORY_LEN_DEF = 12;

    localparam logic [CNT_W-1:0]   INTERVAL_RST = 8'd25;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_OVF    = 4'd10;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [DIGIT_W-1:0]  t_digit;
    typedef logic [SEG_W-1:0]    t_seg;

    // Pipeline advance controls handed from the top level to the stage modules.
    typedef struct packed {
        logic en2;
        logic en3;
        logic load4;
    } t_adv;

    // Segment patterns, bit 0 is segment a and bit 6 is segment g, active high.
    // Every code above nine shows the overflow symbol (segments a, b and f).
    function automatic t_seg seg_pattern(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h23;
        endcase
        return s;
    endfunction

endpackage

### rtl/avd_cell.sv
// One cell of the sample history chain: it holds one sample.
// It depends on avd_pkg for the sample type.
module avd_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  avd_pkg::t_sample i_din,
    output avd_pkg::t_sample o_dout
);

    avd_pkg::t_sample r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_din;
        end
    end

    assign o_dout = r_data;

endmodule

### rtl/avd_recip.sv
// Reciprocal multiply stage that turns the running sum into the floored mean.
// It depends on avd_pkg; the multiplier constant is fixed at elaboration.
module avd_recip #(
    parameter int HISTORY_LEN = avd_pkg::HISTORY_LEN_DEF,
    parameter int SUM_W       = avd_pkg::SAMPLE_W + $clog2(HISTORY_LEN)
) (
    input  logic               i_clk,
    input  avd_pkg::t_adv      i_adv,
    input  logic [SUM_W-1:0]   i_sum,
    input  logic               i_latch,
    output avd_pkg::t_sample   o_avg,
    output logic               o_latch
);

    // Exact floor division for every sum below 2**SUM_W: m = ceil(2**K / N).
    localparam int SHIFT_K           = SUM_W + $clog2(HISTORY_LEN);
    localparam int MULT_W            = SUM_W + 1;
    localparam int PROD_W            = SUM_W + MULT_W;
    localparam longint unsigned MULT =
        ((64'd1 << SHIFT_K) + 64'(HISTORY_LEN) - 64'd1) / 64'(HISTORY_LEN);

    logic [PROD_W-1:0] r_prod;
    logic              r_latch;

    always_ff @(posedge i_clk) begin
        if (i_adv.en2) begin
            r_prod  <= PROD_W'(i_sum) * PROD_W'(MULT_W'(MULT));
            r_latch <= i_latch;
        end
    end

    assign o_avg   = r_prod[SHIFT_K +: avd_pkg::SAMPLE_W];
    assign o_latch = r_latch;

endmodule

### rtl/avd_digits.sv
// Decimal split of the mean, held display digits and the output registers.
// It depends on avd_pkg for widths, digit codes and the segment function.
module avd_digits (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  avd_pkg::t_adv    i_adv,
    input  avd_pkg::t_sample i_avg,
    input  logic             i_latch,
    output avd_pkg::t_sample o_average_value,
    output avd_pkg::t_digit  o_digit_hundreds,
    output avd_pkg::t_digit  o_digit_tens,
    output avd_pkg::t_digit  o_digit_ones,
    output avd_pkg::t_seg    o_segments_hundreds,
    output avd_pkg::t_seg    o_segments_tens,
    output avd_pkg::t_seg    o_segments_ones,
    output logic             o_digits_updated
);

    localparam int REST_W = 7;

    // Stage three: hundreds digit and the remainder below it.
    avd_pkg::t_sample      r_avg;
    avd_pkg::t_digit       r_hund;
    logic [REST_W-1:0]     r_rest;
    logic                  r_latch;
    avd_pkg::t_digit       n_hund;
    logic [REST_W-1:0]     n_rest;

    // Stage four: tens and ones, then the held digits.
    avd_pkg::t_digit       r_held_h;
    avd_pkg::t_digit       r_held_t;
    avd_pkg::t_digit       r_held_o;
    avd_pkg::t_digit       n_tens;
    avd_pkg::t_digit       n_ones;
    avd_pkg::t_digit       n_held_h;
    avd_pkg::t_digit       n_held_t;
    avd_pkg::t_digit       n_held_o;
    logic [REST_W-1:0]     w_ones_raw;

    always_comb begin
        n_hund = '0;
        n_rest = i_avg[REST_W-1:0];
        for (int k = 1; k <= 9; k++) begin
            if (i_avg >= avd_pkg::SAMPLE_W'(k * 100)) begin
                n_hund = avd_pkg::DIGIT_W'(k);
                n_rest = REST_W'(i_avg - avd_pkg::SAMPLE_W'(k * 100));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.en3) begin
            r_avg   <= i_avg;
            r_hund  <= n_hund;
            r_rest  <= n_rest;
            r_latch <= i_latch;
        end
    end

    // The remainder reaches 100 or more only for means of 1000 and above.
    always_comb begin
        n_tens     = '0;
        w_ones_raw = r_rest;
        for (int k = 1; k <= 9; k++) begin
            if (r_rest >= REST_W'(k * 10)) begin
                n_tens     = avd_pkg::DIGIT_W'(k);
                w_ones_raw = r_rest - REST_W'(k * 10);
            end
        end
        n_ones = w_ones_raw[avd_pkg::DIGIT_W-1:0];
        if (w_ones_raw > REST_W'(avd_pkg::DIGIT_MAX)) begin
            n_tens = avd_pkg::DIGIT_OVF;
            n_ones = avd_pkg::DIGIT_OVF;
        end
    end

    always_comb begin
        n_held_h = r_held_h;
        n_held_t = r_held_t;
        n_held_o = r_held_o;
        if (r_latch) begin
            n_held_h = r_hund;
            n_held_t = n_tens;
            n_held_o = n_ones;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_h <= '0;
            r_held_t <= '0;
            r_held_o <= '0;
        end else if (i_adv.load4) begin
            r_held_h <= n_held_h;
            r_held_t <= n_held_t;
            r_held_o <= n_held_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.load4) begin
            o_average_value     <= r_avg;
            o_digit_hundreds    <= n_held_h;
            o_digit_tens        <= n_held_t;
            o_digit_ones        <= n_held_o;
            o_segments_hundreds <= avd_pkg::seg_pattern(n_held_h);
            o_segments_tens     <= avd_pkg::seg_pattern(n_held_t);
            o_segments_ones     <= avd_pkg::seg_pattern(n_held_o);
            o_digits_updated    <= r_latch;
        end
    end

endmodule

### rtl/averaging_voltmeter_display_top.sv
// Top level of the averaging voltmeter display: history chain, running sum,
// update counter and pipeline control. It depends on avd_pkg, avd_cell,
// avd_recip and avd_digits.
//
//   Channel  | Valid    | Stall    | Payload
//   ---------+----------+----------+------------------------------------------
//   input    | i_valid  | o_stall  | i_sample
//   output   | o_valid  | i_stall  | o_average_value, o_digit_*, o_segments_*,
//            |          |          | o_digits_updated
//   config   | i_cfg_we | (none)   | i_cfg_wdata (update interval)
//
// One transaction is taken every cycle while o_stall is low. Each result passes
// through four register stages in order: sum, reciprocal multiply, hundreds
// split, and tens/ones split with the output register. The sum stage loads at
// the accepting edge itself.
// Reset is synchronous and active low; it clears the history, the running sum,
// the counter and the held digits, and sets the interval to 25.
// Each stage moves on when the stage after it is empty or moving, so a stall
// at the output fills the empty stages before the input is stalled.
module averaging_voltmeter_display_top #(
    parameter int HISTORY_LEN = avd_pkg::HISTORY_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [avd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_cfg_we,
    input  logic [avd_pkg::CNT_W-1:0]    i_cfg_wdata,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [avd_pkg::SAMPLE_W-1:0] o_average_value,
    output logic [avd_pkg::DIGIT_W-1:0]  o_digit_hundreds,
    output logic [avd_pkg::DIGIT_W-1:0]  o_digit_tens,
    output logic [avd_pkg::DIGIT_W-1:0]  o_digit_ones,
    output logic [avd_pkg::SEG_W-1:0]    o_segments_hundreds,
    output logic [avd_pkg::SEG_W-1:0]    o_segments_tens,
    output logic [avd_pkg::SEG_W-1:0]    o_segments_ones,
    output logic                         o_digits_updated
);

    // The sum of HISTORY_LEN ten-bit samples always fits in this width.
    localparam int SUM_W = avd_pkg::SAMPLE_W + $clog2(HISTORY_LEN);

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic w_en1;
    logic w_en2;
    logic w_en3;
    logic w_en4;
    logic w_accept;
    avd_pkg::t_adv w_adv;

    avd_pkg::t_sample w_cell [HISTORY_LEN];

    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          n_sum;
    logic [avd_pkg::CNT_W-1:0] r_cnt;
    logic [avd_pkg::CNT_W-1:0] n_cnt;
    logic [avd_pkg::CNT_W-1:0] r_interval;
    logic                      r_latch1;
    logic                      n_latch;

    avd_pkg::t_sample w_avg;
    logic             w_latch2;

    // Stage advance chain, from the output back to the input.
    assign w_en4    = !r_v4 || !i_stall;
    assign w_en3    = !r_v3 || w_en4;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign w_accept = i_valid && w_en1;
    assign o_stall  = !w_en1;
    assign o_valid  = r_v4;

    assign w_adv.en2   = w_en2;
    assign w_adv.en3   = w_en3;
    assign w_adv.load4 = w_en4 && r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_accept;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // History chain: cell 0 holds the oldest sample, the last cell the newest.
    for (genvar g = 0; g < HISTORY_LEN; g++) begin : g_hist
        if (g == HISTORY_LEN - 1) begin : g_tail
            avd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_din   (i_sample),
                .o_dout  (w_cell[g])
            );
        end else begin : g_body
            avd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_din   (w_cell[g+1]),
                .o_dout  (w_cell[g])
            );
        end
    end

    // The running sum drops the sample that leaves cell 0 and adds the new one.
    assign n_sum = r_sum + SUM_W'(i_sample) - SUM_W'(w_cell[0]);

    // The counter clears when it reaches the interval, which latches new digits, and
    // an interval of zero latches on every transaction.
    always_comb begin
        n_cnt   = r_cnt + 1'b1;
        n_latch = 1'b0;
        if (n_cnt >= r_interval) begin
            n_cnt   = '0;
            n_latch = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_cnt      <= '0;
            r_interval <= avd_pkg::INTERVAL_RST;
        end else begin
            if (w_accept) begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_latch1 <= n_latch;
        end
    end

    avd_recip #(
        .HISTORY_LEN (HISTORY_LEN),
        .SUM_W       (SUM_W)
    ) u_recip (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_sum   (r_sum),
        .i_latch (r_latch1),
        .o_avg   (w_avg),
        .o_latch (w_latch2)
    );

    avd_digits u_digits (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_adv               (w_adv),
        .i_avg               (w_avg),
        .i_latch             (w_latch2),
        .o_average_value     (o_average_value),
        .o_digit_hundreds    (o_digit_hundreds),
        .o_digit_tens        (o_digit_tens),
        .o_digit_ones        (o_digit_ones),
        .o_segments_hundreds (o_segments_hundreds),
        .o_segments_tens     (o_segments_tens),
        .o_segments_ones     (o_segments_ones),
        .o_digits_updated    (o_digits_updated)
    );

    // The input is only held off when the first stage still has a transaction.
    a_stall_needs_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v1)
        else $error("input stalled with an empty first stage");

    // A transaction that latches digits leaves the counter at zero.
    a_latch_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_latch) |=> (r_cnt == '0))
        else $error("counter not cleared after a digit latch");

    // The overflow symbol always fills both lower places under a nine.
    a_overflow_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_digit_tens == avd_pkg::DIGIT_OVF)) |->
            ((o_digit_ones == avd_pkg::DIGIT_OVF) &&
             (o_digit_hundreds == avd_pkg::DIGIT_MAX)))
        else $error("malformed overflow display");

    // Displayed digits stay within their codes.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_hundreds <= avd_pkg::DIGIT_MAX) &&
                     (o_digit_tens <= avd_pkg::DIGIT_OVF) &&
                     (o_digit_ones <= avd_pkg::DIGIT_OVF)))
        else $error("display digit out of range");

endmodule

### verif/averaging_voltmeter_display_top_tb.sv
// Self-checking testbench for averaging_voltmeter_display_top: directed bring-up rows,
// then random sample streams under several update intervals with random idling.
// Depends on avd_pkg and the RTL of the block; it reads no files.
module averaging_voltmeter_display_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH  = avd_pkg::HISTORY_LEN_DEF;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int N_PHASES    = 6;

    // One displayed reading: the running mean plus the held display state.
    typedef struct packed {
        avd_pkg::t_sample avg;
        avd_pkg::t_digit  hun;
        avd_pkg::t_digit  ten;
        avd_pkg::t_digit  one;
        avd_pkg::t_seg    seg_h;
        avd_pkg::t_seg    seg_t;
        avd_pkg::t_seg    seg_o;
        logic             upd;
    } t_reading;

    // A bring-up row: the sample and, where it is obvious, the mean and update flag.
    typedef struct packed {
        avd_pkg::t_sample smp;
        logic             chk;
        avd_pkg::t_sample avg;
        logic             upd;
    } t_bringup_row;

    // Segment font, bit 0 is segment a; codes above nine show the overflow symbol.
    localparam avd_pkg::t_seg DISPLAY_FONT [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h23, 7'h23, 7'h23, 7'h23, 7'h23, 7'h23
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    avd_pkg::t_sample          sample    = '0;
    logic                      cfg_we    = 1'b0;
    logic [avd_pkg::CNT_W-1:0] cfg_wdata = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    avd_pkg::t_sample          avg_value;
    avd_pkg::t_digit           dig_h, dig_t, dig_o;
    avd_pkg::t_seg             seg_h, seg_t, seg_o;
    logic                      digits_updated;

    // Predictor state: sample window, update counter, interval and held digits.
    avd_pkg::t_sample          window_q [HIST_DEPTH];
    logic [avd_pkg::CNT_W-1:0] tick_cnt;
    logic [avd_pkg::CNT_W-1:0] interval_reg;
    avd_pkg::t_digit           shown_h, shown_t, shown_o;

    t_reading                  pending_q [$];
    int                        mismatches = 0;
    int                        n_accepted = 0;
    int                        cycles     = 0;
    int                        hold_left  = 0;
    bit                        hold_taken = 1'b0;
    bit                        steady     = 1'b0;
    int                        level      = 512;

    // The first transactions after reset: a zero, a full-scale run that fills the
    // window, then a run of 1000 so that the 25th transaction (the reset interval)
    // latches a mean of exactly 1000 and shows 9 followed by two overflow symbols.
    t_bringup_row bringup [25] = '{
        '{10'd0,    1'b1, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b0, 10'd0,    1'b0},
        '{10'd1023, 1'b1, 10'd1023, 1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b0, 10'd0,    1'b0},
        '{10'd1000, 1'b1, 10'd1000, 1'b1}
    };

    // Update intervals of the random phases: the always-latch case, both ends of
    // the range, a short one and a mid value; the last phase draws its own.
    logic [avd_pkg::CNT_W-1:0] interval_plan [N_PHASES] =
        '{8'd0, 8'd1, 8'd255, 8'd2, 8'd13, 8'd0};
    int                        length_plan   [N_PHASES] = '{120, 120, 520, 150, 150, 240};

    averaging_voltmeter_display_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (in_valid),
        .o_stall             (in_stall),
        .i_sample            (sample),
        .i_cfg_we            (cfg_we),
        .i_cfg_wdata         (cfg_wdata),
        .o_valid             (out_valid),
        .i_stall             (out_stall),
        .o_average_value     (avg_value),
        .o_digit_hundreds    (dig_h),
        .o_digit_tens        (dig_t),
        .o_digit_ones        (dig_o),
        .o_segments_hundreds (seg_h),
        .o_segments_tens     (seg_t),
        .o_segments_ones     (seg_o),
        .o_digits_updated    (digits_updated)
    );

    always #5 clk = ~clk;

    // Puts the predictor back into its post-reset state.
    function automatic void clear_meter();
        for (int k = 0; k < HIST_DEPTH; k++) begin
            window_q[k] = '0;
        end
        tick_cnt     = '0;
        interval_reg = avd_pkg::INTERVAL_RST;
        shown_h      = '0;
        shown_t      = '0;
        shown_o      = '0;
    endfunction

    // Shifts one sample into the window, forms the floored mean and, when the
    // update counter reaches the interval, splits the mean into held digits.
    function automatic t_reading advance_meter(input avd_pkg::t_sample s);
        t_reading    r;
        int unsigned total;
        int unsigned mean;
        int unsigned h, rest, t, o;
        total = 0;
        for (int k = 0; k < HIST_DEPTH - 1; k++) begin
            window_q[k] = window_q[k + 1];
        end
        window_q[HIST_DEPTH - 1] = s;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            total += window_q[k];
        end
        mean     = total / HIST_DEPTH;
        r.upd    = 1'b0;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= interval_reg) begin
            tick_cnt = '0;
            r.upd    = 1'b1;
            h = mean / 100;
            if (h > avd_pkg::DIGIT_MAX) begin
                h = avd_pkg::DIGIT_MAX;
            end
            rest = mean - h * 100;
            t = rest / 10;
            if (t > avd_pkg::DIGIT_MAX) begin
                t = avd_pkg::DIGIT_MAX;
            end
            o = rest - t * 10;
            // A mean of 1000 or more cannot be shown; the tens and ones fall
            // back to the overflow symbol.
            if (o > avd_pkg::DIGIT_MAX) begin
                t = avd_pkg::DIGIT_OVF;
                o = avd_pkg::DIGIT_OVF;
            end
            shown_h = avd_pkg::t_digit'(h);
            shown_t = avd_pkg::t_digit'(t);
            shown_o = avd_pkg::t_digit'(o);
        end
        r.avg   = avd_pkg::t_sample'(mean);
        r.hun   = shown_h;
        r.ten   = shown_t;
        r.one   = shown_o;
        r.seg_h = DISPLAY_FONT[shown_h];
        r.seg_t = DISPLAY_FONT[shown_t];
        r.seg_o = DISPLAY_FONT[shown_o];
        return r;
    endfunction

    // Readings that most often hover around a level, as a real voltmeter would see,
    // with a good share near the top where the overflow display kicks in, plus
    // uniform noise and the hard corners.
    function automatic avd_pkg::t_sample pick_sample();
        int v;
        v = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom_range(0, 1023);
            3, 4, 5, 6: begin
                v = level + $urandom_range(0, 16) - 8;
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
            end
            7, 8: v = $urandom_range(985, 1023);
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 1023;
                    2: v = 999;
                    default: v = 1000;
                endcase
            end
        endcase
        return avd_pkg::t_sample'(v);
    endfunction

    // Offers one sample, waits for the transaction and records what the display
    // should show for it. A typed mean and update flag replace the prediction
    // on bring-up rows that carry them.
    task automatic offer_sample(input avd_pkg::t_sample s, input logic chk,
                                input avd_pkg::t_sample avg_k, input logic upd_k);
        t_reading e;
        in_valid <= 1'b1;
        sample   <= s;
        do begin
            @(posedge clk);
        end while (in_stall);
        e = advance_meter(s);
        if (chk) begin
            e.avg = avg_k;
            e.upd = upd_k;
        end
        pending_q.push_back(e);
        n_accepted++;
        if (!steady && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Waits for the pipeline to drain and then writes a new update interval.
    task automatic set_interval(input logic [avd_pkg::CNT_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        interval_reg  = v;
    endtask

    // Receiver side. It stalls about a quarter of the cycles, never during the
    // steady phase, and once holds off for a long stretch late in the
    // long phase so that the pipeline fills and pushes back on the sender.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_taken && n_accepted >= 700) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES - 1;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= !steady && ($urandom_range(0, 99) < 26);
        end
    end

    // Result checker: every output transaction is matched against the oldest
    // outstanding expectation.
    always @(posedge clk) begin
        t_reading got, e;
        if (rst_n && out_valid && !out_stall) begin
            got = '{avg_value, dig_h, dig_t, dig_o, seg_h, seg_t, seg_o, digits_updated};
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result transaction: avg=%0d", avg_value);
                end
            end else begin
                e = pending_q.pop_front();
                if (got !== e) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch exp: avg=%0d digits=%0d/%0d/%0d seg=%h/%h/%h upd=%b",
                                 e.avg, e.hun, e.ten, e.one, e.seg_h, e.seg_t, e.seg_o,
                                 e.upd);
                        $display("         got: avg=%0d digits=%0d/%0d/%0d seg=%h/%h/%h upd=%b",
                                 got.avg, got.hun, got.ten, got.one, got.seg_h, got.seg_t,
                                 got.seg_o, got.upd);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [avd_pkg::CNT_W-1:0] ivl;
        clear_meter();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Bring-up rows run at the reset interval of 25.
        foreach (bringup[i]) begin
            offer_sample(bringup[i].smp, bringup[i].chk, bringup[i].avg, bringup[i].upd);
        end

        // Random phases, each under its own interval. The interval-2 phase runs
        // with no idling on either side.
        for (int p = 0; p < N_PHASES; p++) begin
            ivl = (p == N_PHASES - 1) ? avd_pkg::CNT_W'($urandom_range(3, 254))
                                      : interval_plan[p];
            set_interval(ivl);
            steady = (p == 3);
            level  = $urandom_range(0, 1023);
            for (int i = 0; i < length_plan[p]; i++) begin
                if ($urandom_range(0, 49) == 0) begin
                    level = $urandom_range(0, 1023);
                end
                offer_sample(pick_sample(), 1'b0, '0, 1'b0);
            end
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
